FILE: hw/rtl/sensor_uart_frame_parser_assert.svh
// Assertion macros used by the frame parser checker.
// Needs nothing but a clock and an active-low reset in scope of the user.
`ifndef SENSOR_UART_FRAME_PARSER_ASSERT_SVH
`define SENSOR_UART_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, off while in reset
`define SUFP_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, active during reset too
`define SUFP_ASSERT_NXT(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sufp_pkg.sv
// Shared types and constants of the sensor UART frame parser.
// No dependencies.
package sufp_pkg;

  localparam int MAX_PAYLOAD = 15;
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 5);
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] SYNC_BYTE  = 8'h5A;
  localparam logic [7:0] TEMP_TYPE  = 8'h45;
  localparam int         TEMP_BYTES = 4;
  localparam int         HDR_BYTES  = 4;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } sufp_byte_t;

  typedef struct packed {
    logic [15:0] object_temp;
    logic [15:0] ambient_temp;
    logic        checksum_ok;
  } sufp_result_t;

endpackage

FILE: hw/rtl/sensor_uart_frame_parser.sv
// Top level of the sensor UART frame parser: input register feeding the parser core.
// Depends on sufp_pkg, sufp_in_reg and sufp_core.
//
//   channel   signals                                          direction
//   in        in_valid, in_ready, in_rx_byte                   byte in
//   out       out_valid, out_ready, out_object_temp,           result out
//             out_ambient_temp, out_checksum_ok
//
// One byte per cycle unless a stalled result holds the input, set by the core's
// state update; a result is registered when the core takes its checksum byte.
// Reset (rst_n low, synchronous) clears the search state and drops held items.
// A stalled result blocks only a byte that would give another result; other bytes
// keep flowing.
module sensor_uart_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_object_temp,
  output logic [15:0] out_ambient_temp,
  output logic        out_checksum_ok
);
  import sufp_pkg::*;

  sufp_byte_t   held;
  sufp_result_t res;
  logic         take;

  sufp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .held       (held)
  );

  sufp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .held      (held),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_object_temp  = res.object_temp;
  assign out_ambient_temp = res.ambient_temp;
  assign out_checksum_ok  = res.checksum_ok;

endmodule

FILE: hw/rtl/sufp_in_reg.sv
// Input register of the frame parser: holds one received byte until the core takes it.
// Depends on sufp_pkg.
module sufp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              take,
  output sufp_pkg::sufp_byte_t held
);
  import sufp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (take) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      data_nxt  = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign held.valid = valid_r;
  assign held.data  = data_r;

endmodule

FILE: hw/rtl/sufp_core.sv
// Frame parser core: header sync, length check, running sum, and result register.
// Depends on sufp_pkg.
module sufp_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sufp_pkg::sufp_byte_t   held,
  output logic                   take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sufp_pkg::sufp_result_t res
);
  import sufp_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      obj_r, obj_nxt;
  logic [15:0]      amb_r, amb_nxt;
  logic             out_valid_r, out_valid_nxt;
  sufp_result_t     res_r, res_nxt;

  logic [CNT_W-1:0] pos;
  logic             in_payload;
  logic             is_csum;
  logic             emit;
  logic             ok;
  logic [7:0]       b;

  assign b          = held.data;
  assign pos        = count_r - CNT_W'(HDR_BYTES);
  assign in_payload = pos < CNT_W'(len_r);
  assign is_csum    = (count_r >= CNT_W'(HDR_BYTES)) && !in_payload;
  assign emit       = is_csum && (type_r == TEMP_TYPE);
  assign ok         = (sum_r == b);
  assign take       = held.valid && (!emit || !out_valid_r || out_ready);

  always_comb begin
    count_nxt     = count_r;
    type_nxt      = type_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    obj_nxt       = obj_r;
    amb_nxt       = amb_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    if (take) begin
      if (count_r == CNT_W'(0)) begin
        if (b == SYNC_BYTE) begin
          sum_nxt   = b;
          count_nxt = CNT_W'(1);
        end
      end else if (count_r == CNT_W'(1)) begin
        if (b == SYNC_BYTE) begin
          sum_nxt   = sum_r + b;
          count_nxt = CNT_W'(2);
        end else begin
          count_nxt = CNT_W'(0);
        end
      end else if (count_r == CNT_W'(2)) begin
        type_nxt  = b;
        sum_nxt   = sum_r + b;
        count_nxt = CNT_W'(3);
      end else if (count_r == CNT_W'(3)) begin
        if (b > 8'(MAX_PAYLOAD)) begin
          count_nxt = CNT_W'(0);
        end else begin
          len_nxt   = LEN_W'(b);
          sum_nxt   = sum_r + b;
          obj_nxt   = 16'h0000;
          amb_nxt   = 16'h0000;
          count_nxt = CNT_W'(HDR_BYTES);
        end
      end else if (in_payload) begin
        case (pos)
          CNT_W'(0): obj_nxt[15:8] = b;
          CNT_W'(1): obj_nxt[7:0]  = b;
          CNT_W'(2): amb_nxt[15:8] = b;
          CNT_W'(3): amb_nxt[7:0]  = b;
          default:   ;
        endcase
        sum_nxt   = sum_r + b;
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = CNT_W'(0);
        if (emit) begin
          out_valid_nxt       = 1'b1;
          res_nxt.checksum_ok = ok;
          if (ok && (len_r >= LEN_W'(TEMP_BYTES))) begin
            res_nxt.object_temp  = obj_r;
            res_nxt.ambient_temp = amb_r;
          end else begin
            res_nxt.object_temp  = 16'h0000;
            res_nxt.ambient_temp = 16'h0000;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      type_r      <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      obj_r       <= '0;
      amb_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      type_r      <= type_nxt;
      len_r       <= len_nxt;
      sum_r       <= sum_nxt;
      obj_r       <= obj_nxt;
      amb_r       <= amb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

FILE: hw/rtl/sufp_checker.sv
// Port-level checker for the sensor UART frame parser, bound to the top level.
// Depends on sensor_uart_frame_parser_assert.svh.
`include "sensor_uart_frame_parser_assert.svh"

module sufp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_object_temp,
  input logic [15:0] out_ambient_temp,
  input logic        out_checksum_ok
);

  logic        in_stall;
  logic        out_stall;
  logic        out_zero;
  logic [32:0] out_payload;

  assign in_stall    = rst_n && in_valid && !in_ready;
  assign out_stall   = rst_n && out_valid && !out_ready;
  assign out_zero    = (out_object_temp == 16'h0000) && (out_ambient_temp == 16'h0000);
  assign out_payload = {out_object_temp, out_ambient_temp, out_checksum_ok};

  `SUFP_ASSERT_NXT(a_out_hold, clk, out_stall, out_valid && $stable(out_payload))
  `SUFP_ASSERT_IMP(a_bad_sum_zero, clk, rst_n, out_valid && !out_checksum_ok, out_zero)
  `SUFP_ASSERT_NXT(a_reset_clear, clk, !rst_n, !out_valid)
  `SUFP_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `SUFP_ASSERT_NXT(a_in_hold, clk, in_stall, in_valid && $stable(in_rx_byte))

endmodule

bind sensor_uart_frame_parser sufp_checker u_sufp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_object_temp  (out_object_temp),
  .out_ambient_temp (out_ambient_temp),
  .out_checksum_ok  (out_checksum_ok)
);
